// ===== hw/rtl/pls_pkg.sv =====
// Shared types, codes and elaboration helpers for the positional list store.
// No dependencies; every other file of the block imports this package.
package pls_pkg;

    // Request codes on the op field.
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_ERASE  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_RANGE = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // Fixed field widths of the channels.
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 8;
    localparam int STS_W   = 2;
    localparam int COUNT_W = 7;

    // Fan-in of one node of the read-back reduction tree.
    localparam int TREE_FANIN = 8;

    // Broadcast command seen by every cell of the row.
    typedef struct packed {
        logic ins;   // open a slot at the position, shift later elements up
        logic del;   // close the slot at the position, shift later elements down
        logic rd;    // present the element at the position to the read tree
        logic smp;   // reload the read leaf; hold the last one otherwise
    } t_cell_cmd;

    // Number of registered 8:1 levels needed to reduce n leaves to one.
    function automatic int pls_levels(input int n);
        int lvl;
        int span;
        lvl  = 1;
        span = TREE_FANIN;
        for (int k = 0; k < 8; k++) begin
            if (span < n) begin
                span = span * TREE_FANIN;
                lvl  = lvl + 1;
            end
        end
        return lvl;
    endfunction

endpackage

// ===== hw/rtl/pls_cell.sv =====
// One element slot of the positional list store row.
// Depends on pls_pkg for the broadcast command type.
module pls_cell #(
    parameter int IDX = 0,
    parameter int PW  = 7,
    parameter int DW  = 8
) (
    input  logic                  i_clk,
    input  pls_pkg::t_cell_cmd    i_cmd,
    input  logic [PW-1:0]         i_pos,
    input  logic [DW-1:0]         i_value,
    input  logic [DW-1:0]         i_left,
    input  logic [DW-1:0]         i_right,
    output logic [DW-1:0]         o_value,
    output logic [DW-1:0]         o_hit
);
    import pls_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [DW-1:0] r_value;
    logic [DW-1:0] n_value;
    logic [DW-1:0] r_hit;
    logic [DW-1:0] n_hit;

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (MY_IDX == i_pos) begin
                n_value = i_value;
            end else if (MY_IDX > i_pos) begin
                n_value = i_left;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_pos) begin
                n_value = i_right;
            end
        end
        // Hold the leaf between requests so the tree output stays put.
        n_hit = r_hit;
        if (i_cmd.smp) begin
            n_hit = (i_cmd.rd && (MY_IDX == i_pos)) ? r_value : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_hit   <= n_hit;
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule

// ===== hw/rtl/pls_or_tree.sv =====
// Registered 8:1 OR-reduction tree that gathers the one selected cell value.
// Depends on pls_pkg for the level count helper and fan-in.
module pls_or_tree #(
    parameter int N = 64,
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_leaf [N],
    output logic [W-1:0] o_root
);
    import pls_pkg::*;

    function automatic int node_off(input int npad, input int lvl);
        int acc;
        acc = 0;
        for (int k = 1; k < 16; k++) begin
            if (k < lvl) begin
                acc = acc + (npad >> (3 * k));
            end
        end
        return acc;
    endfunction

    localparam int LEVELS = pls_levels(N);
    localparam int NPAD   = 1 << (3 * LEVELS);
    localparam int TOTAL  = node_off(NPAD, LEVELS + 1);

    logic [W-1:0] w_pad  [NPAD];
    logic [W-1:0] n_node [TOTAL];
    logic [W-1:0] r_node [TOTAL];

    genvar gi, gl, gj;

    for (gi = 0; gi < NPAD; gi++) begin : g_pad
        if (gi < N) begin : g_real
            assign w_pad[gi] = i_leaf[gi];
        end else begin : g_zero
            assign w_pad[gi] = '0;
        end
    end

    for (gl = 1; gl <= LEVELS; gl++) begin : g_lvl
        for (gj = 0; gj < (NPAD >> (3 * gl)); gj++) begin : g_node
            localparam int DST = node_off(NPAD, gl) + gj;
            localparam int SRC = node_off(NPAD, gl - 1) + gj * TREE_FANIN;
            localparam int LB  = gj * TREE_FANIN;
            if (gl == 1) begin : g_first
                assign n_node[DST] = w_pad[LB] | w_pad[LB+1] | w_pad[LB+2] | w_pad[LB+3]
                                   | w_pad[LB+4] | w_pad[LB+5] | w_pad[LB+6] | w_pad[LB+7];
            end else begin : g_inner
                assign n_node[DST] = r_node[SRC] | r_node[SRC+1] | r_node[SRC+2]
                                   | r_node[SRC+3] | r_node[SRC+4] | r_node[SRC+5]
                                   | r_node[SRC+6] | r_node[SRC+7];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
    end

    assign o_root = r_node[TOTAL-1];

endmodule

// ===== hw/rtl/positional_list_store.sv =====
// Top level of the positional list store: control, element count and cell row.
// Depends on pls_pkg, pls_cell and pls_or_tree.
//
// Usage
//   Request channel: i_in_valid / o_in_stall with i_op, i_position, i_item_value.
//   Result channel:  o_out_valid / i_out_stall with o_status, o_read_value, o_count.
//   An item moves at a rising edge where valid is high and stall is low.
//   Every request gives exactly one result item, in request order.
//   Append, insert and erase take effect on the row of cells at the accept
//   edge: every cell after the position (for erase, from the position on)
//   takes its neighbor's value in that same cycle; clear resets only the
//   count. A read gates the selected cell into a registered 8:1 OR tree of
//   L = ceil(log8(CAPACITY)) levels (L = 2 for 64 entries). No new item is
//   taken while one is in flight; the next item is taken in the cycle its
//   predecessor moves to the output register, so a waiting result does not
//   block the next request.
//   Reset (synchronous, active low) empties the store and drops any item in
//   flight; element storage is not cleared, and only filled slots are read.
//   While the receiver stalls, the result holds on the output ports and the
//   block stops taking requests once a second result is ready behind it.
module positional_list_store #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pls_pkg::OP_W-1:0]      i_op,
    input  logic [pls_pkg::POS_W-1:0]     i_position,
    input  logic [pls_pkg::VAL_W-1:0]     i_item_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pls_pkg::STS_W-1:0]     o_status,
    output logic [pls_pkg::VAL_W-1:0]     o_read_value,
    output logic [pls_pkg::COUNT_W-1:0]   o_count
);
    import pls_pkg::*;

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int XW     = (CW > POS_W) ? CW : POS_W;
    localparam int VW     = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
    localparam int LEVELS = pls_levels(CAPACITY);
    localparam int WW     = $clog2(LEVELS + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [WW-1:0] WAIT_INIT = WW'(LEVELS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WORK = 2'b10
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [WW-1:0]       r_wait;
    logic [WW-1:0]       n_wait;
    logic [STS_W-1:0]    r_pend_status;
    logic [STS_W-1:0]    n_pend_status;
    logic [CW-1:0]       r_pend_count;
    logic                r_out_valid;
    logic [STS_W-1:0]    r_status;
    logic [VAL_W-1:0]    r_read_value;
    logic [COUNT_W-1:0]  r_count_out;

    logic                w_accept;
    logic                w_xfer;
    logic                w_full;
    logic [XW-1:0]       w_pos_x;
    logic [XW-1:0]       w_cnt_x;
    logic [VW-1:0]       w_val_x;
    logic [VW-1:0]       w_rd_x;
    logic [XW-1:0]       w_pend_cnt_x;
    t_cell_cmd           w_cmd;
    logic [CW-1:0]       w_cell_pos;
    logic [DATA_WIDTH-1:0] w_cell_in;
    logic [DATA_WIDTH-1:0] w_cell_val [CAPACITY];
    logic [DATA_WIDTH-1:0] w_hit      [CAPACITY];
    logic [DATA_WIDTH-1:0] w_root;

    // Hand off the finished item when the output register is free or draining.
    assign w_xfer     = (r_state == ST_WORK) && (r_wait == '0)
                        && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state == ST_WORK) && !w_xfer;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full    = (r_count == CAP);
    assign w_pos_x   = XW'(i_position);
    assign w_cnt_x   = XW'(r_count);
    assign w_val_x   = VW'(i_item_value);
    assign w_cell_in = w_val_x[DATA_WIDTH-1:0];

    // Decode the request against the current count.
    always_comb begin
        w_cmd         = '0;
        w_cell_pos    = w_pos_x[CW-1:0];
        n_count       = r_count;
        n_pend_status = STS_DONE;
        case (i_op)
            OP_APPEND: begin
                if (w_full) begin
                    n_pend_status = STS_FULL;
                end else begin
                    w_cmd.ins  = 1'b1;
                    w_cell_pos = r_count;
                    n_count    = r_count + 1'b1;
                end
            end
            OP_INSERT: begin
                if (w_pos_x > w_cnt_x) begin
                    n_pend_status = STS_RANGE;
                end else if (w_full) begin
                    n_pend_status = STS_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            OP_ERASE: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_pend_status = STS_RANGE;
                end else begin
                    w_cmd.del = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            OP_READ: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_pend_status = STS_RANGE;
                end else begin
                    w_cmd.rd = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        // Drop the command on cycles without an accepted item.
        if (!w_accept) begin
            w_cmd   = '0;
            n_count = r_count;
        end
        // Reload the read leaves only on an accepted item, so the gathered
        // value holds in the tree while the finished item waits to move.
        w_cmd.smp = w_accept;
    end

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        if (w_accept) begin
            n_state = ST_WORK;
            n_wait  = WAIT_INIT;
        end else if (w_xfer) begin
            n_state = ST_IDLE;
        end else if ((r_state == ST_WORK) && (r_wait != '0)) begin
            n_wait = r_wait - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wait  <= n_wait;
            if (w_xfer) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold the request's status and count until the tree is done.
    assign w_rd_x       = VW'(w_root);
    assign w_pend_cnt_x = XW'(r_pend_count);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_status <= n_pend_status;
            r_pend_count  <= n_count;
        end
        if (w_xfer) begin
            r_status     <= r_pend_status;
            r_read_value <= w_rd_x[VAL_W-1:0];
            r_count_out  <= w_pend_cnt_x[COUNT_W-1:0];
        end
    end

    // Row of cells; each takes its left or right neighbor on a shift.
    genvar gi;
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (gi == 0) begin : g_lz
            assign w_left = '0;
        end else begin : g_ln
            assign w_left = w_cell_val[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_rz
            assign w_right = '0;
        end else begin : g_rn
            assign w_right = w_cell_val[gi+1];
        end
        pls_cell #(
            .IDX (gi),
            .PW  (CW),
            .DW  (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_cell_pos),
            .i_value (w_cell_in),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell_val[gi]),
            .o_hit   (w_hit[gi])
        );
    end

    pls_or_tree #(
        .N (CAPACITY),
        .W (DATA_WIDTH)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_hit),
        .o_root (w_root)
    );

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;
    assign o_count      = r_count_out;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("element count above capacity");

    // An accepted item keeps the input stalled in the next cycle until its tree drains.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (LEVELS > 0)) |=> o_in_stall)
        else $error("second item taken while the first is in flight");

    // A successful append grows the count by exactly one.
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_APPEND) && !w_full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not grow the count");

    // A clear empties the store.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_CLEAR)) |=> (r_count == '0))
        else $error("clear left elements behind");

endmodule
